[design/dtpw_pkg.sv]
// Shared constants, types and outcome codes for the depth-tested pixel writer.
// No dependencies; every other file in this folder imports this package.
package dtpw_pkg;

    localparam int SCREEN_WIDTH  = 800;
    localparam int SCREEN_HEIGHT = 600;
    localparam int PIXEL_COUNT   = SCREEN_WIDTH * SCREEN_HEIGHT;

    localparam int ADDR_W    = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam int COL_W     = $clog2(SCREEN_WIDTH + 1);
    localparam int ROW_W     = $clog2(SCREEN_HEIGHT + 1);
    localparam int IDX_SUM_W = ROW_W + COL_W + 1;

    localparam int POS_W   = 12;
    localparam int DEPTH_W = 32;
    localparam int COLOR_W = 16;
    localparam int TAG_W   = 8;
    localparam int INDEX_W = 19;
    localparam int WORD_W  = 32;

    localparam logic [7:0] ALPHA_BYTE = 8'hFF;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        OUT_WRITTEN   = 2'd0,
        OUT_OFFSCREEN = 2'd1,
        OUT_HIDDEN    = 2'd2
    } outcome_t;

    // Classified fragment passed from front end to back end
    typedef struct packed {
        logic                offscreen;
        logic [ADDR_W-1:0]   addr;
        logic [DEPTH_W-1:0]  depth;
        logic [WORD_W-1:0]   word;
    } frag_t;

endpackage

[design/dtpw_front.sv]
// Front end: takes fragment requests, range-checks them, forms the pixel
// address and the packed colour word, and registers the result. Uses dtpw_pkg.
module dtpw_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                hold,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [dtpw_pkg::POS_W-1:0]   pixel_x,
    input  logic signed [dtpw_pkg::POS_W-1:0]   pixel_y,
    input  logic signed [dtpw_pkg::DEPTH_W-1:0] depth,
    input  logic signed [dtpw_pkg::COLOR_W-1:0] red_in,
    input  logic signed [dtpw_pkg::COLOR_W-1:0] green_in,
    input  logic signed [dtpw_pkg::COLOR_W-1:0] blue_in,
    output logic                                frag_valid,
    input  logic                                frag_ready,
    output dtpw_pkg::frag_t                     frag
);
    import dtpw_pkg::*;

    localparam logic signed [COLOR_W-1:0] COLOR_ONE = 16'sd4096;

    // Q4.12 to byte: clamp to [0,1], then floor(c * 255 / 4096)
    function automatic logic [7:0] to_byte(input logic signed [COLOR_W-1:0] c);
        logic [19:0] scaled;
        scaled = {c[11:0], 8'b0} - {8'b0, c[11:0]};
        if (c <= 0)
            return 8'd0;
        else if (c >= COLOR_ONE)
            return 8'hFF;
        else
            return scaled[19:12];
    endfunction

    logic signed [POS_W:0]  x_ext;
    logic signed [POS_W:0]  y_ext;
    logic signed [POS_W:0]  row_full;
    logic                   on_screen;
    logic [ROW_W-1:0]       row;
    logic [COL_W-1:0]       col;
    logic [IDX_SUM_W-1:0]   idx_sum;
    frag_t                  frag_next;
    logic                   frag_valid_reg;
    frag_t                  frag_reg;
    logic                   take;

    assign x_ext = $signed({pixel_x[POS_W-1], pixel_x});
    assign y_ext = $signed({pixel_y[POS_W-1], pixel_y});

    assign on_screen = (y_ext > 0) && (y_ext <= (POS_W+1)'(SCREEN_HEIGHT))
                    && (x_ext >= 0) && (x_ext < (POS_W+1)'(SCREEN_WIDTH));

    // Rows count downward from the top of the buffer
    assign row_full = (POS_W+1)'(SCREEN_HEIGHT) - y_ext;
    assign row      = row_full[ROW_W-1:0];
    assign col      = x_ext[COL_W-1:0];
    assign idx_sum  = IDX_SUM_W'(row) * IDX_SUM_W'(SCREEN_WIDTH) + IDX_SUM_W'(col);

    always_comb
    begin
        frag_next.offscreen = !on_screen;
        frag_next.addr      = on_screen ? idx_sum[ADDR_W-1:0] : '0;
        frag_next.depth     = depth;
        frag_next.word      = {ALPHA_BYTE, to_byte(red_in), to_byte(green_in),
                               to_byte(blue_in)};
    end

    assign in_ready   = !hold && (!frag_valid_reg || frag_ready);
    assign take       = in_valid && in_ready;
    assign frag_valid = frag_valid_reg;
    assign frag       = frag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            frag_valid_reg <= 1'b0;
        else if (take)
            frag_valid_reg <= 1'b1;
        else if (frag_ready)
            frag_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            frag_reg <= frag_next;
    end

endmodule

[design/dtpw_queue.sv]
// Short FIFO of classified fragments between front end and back end.
// Uses dtpw_pkg for the entry type and depth.
module dtpw_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  dtpw_pkg::frag_t in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output dtpw_pkg::frag_t out_item
);
    import dtpw_pkg::*;

    frag_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              push;
    logic              pop;

    assign in_ready  = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= in_item;
    end

endmodule

[design/dtpw_back.sv]
// Back end: frame tag and depth memories, depth test with write forwarding,
// buffer update and result register. Also runs the tag clearing pass after reset.
// Uses dtpw_pkg.
module dtpw_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [dtpw_pkg::TAG_W-1:0]       current_frame,
    output logic                             clearing,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  dtpw_pkg::frag_t                  in_item,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [1:0]                       outcome,
    output logic [dtpw_pkg::INDEX_W-1:0]     pixel_index,
    output logic [dtpw_pkg::WORD_W-1:0]      pixel_word
);
    import dtpw_pkg::*;

    logic [TAG_W-1:0]   tag_mem   [PIXEL_COUNT];
    logic [DEPTH_W-1:0] depth_mem [PIXEL_COUNT];

    logic                 clearing_reg;
    logic [ADDR_W-1:0]    clear_addr_reg;
    logic                 s2_valid_reg;
    frag_t                s2_reg;
    logic                 fwd_hit_reg;
    logic [DEPTH_W-1:0]   fwd_depth_reg;
    logic [TAG_W-1:0]     tag_rd_reg;
    logic [DEPTH_W-1:0]   depth_rd_reg;
    logic                 out_valid_reg;
    outcome_t             outcome_reg;
    logic [INDEX_W-1:0]   index_reg;
    logic [WORD_W-1:0]    word_reg;

    logic                 tag_match;
    logic [DEPTH_W-1:0]   depth_eff;
    logic                 hidden;
    logic                 s2_adv;
    logic                 wr_en;
    logic                 pop;
    logic                 tag_we;
    logic [ADDR_W-1:0]    tag_waddr;
    logic [TAG_W-1:0]     tag_wdata;
    logic [ADDR_W+INDEX_W-1:0] idx_wide;
    outcome_t             outcome_next;

    // A write at the same edge as the read is not seen by the read: forward it
    assign tag_match = fwd_hit_reg || (tag_rd_reg == current_frame);
    assign depth_eff = fwd_hit_reg ? fwd_depth_reg : depth_rd_reg;
    assign hidden    = tag_match && ($signed(depth_eff) < $signed(s2_reg.depth));

    assign s2_adv   = s2_valid_reg && (!out_valid_reg || out_ready);
    assign wr_en    = s2_adv && !s2_reg.offscreen && !hidden;
    assign pop      = in_valid && !clearing_reg && (!s2_valid_reg || s2_adv);
    assign in_ready = pop;
    assign clearing = clearing_reg;

    assign tag_we    = clearing_reg || wr_en;
    assign tag_waddr = clearing_reg ? clear_addr_reg : s2_reg.addr;
    assign tag_wdata = clearing_reg ? '0 : current_frame;

    assign idx_wide = {{INDEX_W{1'b0}}, s2_reg.addr};

    always_comb
    begin
        priority if (s2_reg.offscreen)
            outcome_next = OUT_OFFSCREEN;
        else if (hidden)
            outcome_next = OUT_HIDDEN;
        else
            outcome_next = OUT_WRITTEN;
    end

    always_ff @(posedge clk)
    begin
        if (tag_we)
            tag_mem[tag_waddr] <= tag_wdata;
        if (pop)
            tag_rd_reg <= tag_mem[in_item.addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            depth_mem[s2_reg.addr] <= s2_reg.depth;
        if (pop)
            depth_rd_reg <= depth_mem[in_item.addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg   <= 1'b1;
            clear_addr_reg <= '0;
            s2_valid_reg   <= 1'b0;
            fwd_hit_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                if (clear_addr_reg == ADDR_W'(PIXEL_COUNT - 1))
                    clearing_reg <= 1'b0;
                else
                    clear_addr_reg <= clear_addr_reg + 1'b1;
            end

            if (pop)
            begin
                s2_valid_reg <= 1'b1;
                fwd_hit_reg  <= wr_en && (s2_reg.addr == in_item.addr);
            end
            else if (s2_adv)
                s2_valid_reg <= 1'b0;

            if (s2_adv)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s2_reg        <= in_item;
            fwd_depth_reg <= s2_reg.depth;
        end
        if (s2_adv)
        begin
            outcome_reg <= outcome_next;
            index_reg   <= wr_en ? idx_wide[INDEX_W-1:0] : '0;
            word_reg    <= wr_en ? s2_reg.word : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign outcome     = outcome_reg;
    assign pixel_index = index_reg;
    assign pixel_word  = word_reg;

endmodule

[design/depth_test_pixel_writer.sv]
// Depth-tested pixel writer: front end, fragment queue and back end.
// Uses dtpw_pkg, dtpw_front, dtpw_queue and dtpw_back.
//
// Takes one fragment request per clock unless held by clearing or out_ready
// back-pressure, and returns one result per request, in order: written (with
// pixel index and ARGB word), outside the screen, or hidden by depth. After
// reset the frame tag memory is cleared one entry a cycle, during which
// in_ready stays low; cfg writes are taken throughout. Once cleared, the block
// sustains one fragment per cycle through the front, queue, stage and result
// registers; the bound is the single read-then-write of the tag and depth
// memories per cycle, with the previous cycle's write forwarded so repeated
// pixels back to back are tested against the fresh depth. A new frame needs
// only a write of current_frame: stale tags make the stored depth count as
// empty. Write current_frame only while no fragments are in flight.
module depth_test_pixel_writer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [dtpw_pkg::TAG_W-1:0]          cfg_write_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [dtpw_pkg::POS_W-1:0]   pixel_x,
    input  logic signed [dtpw_pkg::POS_W-1:0]   pixel_y,
    input  logic signed [dtpw_pkg::DEPTH_W-1:0] depth,
    input  logic signed [dtpw_pkg::COLOR_W-1:0] red_in,
    input  logic signed [dtpw_pkg::COLOR_W-1:0] green_in,
    input  logic signed [dtpw_pkg::COLOR_W-1:0] blue_in,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          outcome,
    output logic [dtpw_pkg::INDEX_W-1:0]        pixel_index,
    output logic [dtpw_pkg::WORD_W-1:0]         pixel_word
);
    import dtpw_pkg::*;

    logic [TAG_W-1:0] current_frame_reg;
    logic             clearing;
    logic             front_valid;
    logic             front_ready;
    frag_t            front_item;
    logic             queue_valid;
    logic             queue_ready;
    frag_t            queue_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            current_frame_reg <= TAG_W'(1);
        else if (cfg_write_en)
            current_frame_reg <= cfg_write_data;
    end

    dtpw_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .hold       (clearing),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .depth      (depth),
        .red_in     (red_in),
        .green_in   (green_in),
        .blue_in    (blue_in),
        .frag_valid (front_valid),
        .frag_ready (front_ready),
        .frag       (front_item)
    );

    dtpw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_item   (front_item),
        .out_valid (queue_valid),
        .out_ready (queue_ready),
        .out_item  (queue_item)
    );

    dtpw_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .current_frame (current_frame_reg),
        .clearing      (clearing),
        .in_valid      (queue_valid),
        .in_ready      (queue_ready),
        .in_item       (queue_item),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .outcome       (outcome),
        .pixel_index   (pixel_index),
        .pixel_word    (pixel_word)
    );

endmodule
